// ----- rtl/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   localparam int PRIO_BITS = 8;
   localparam int WORD_BITS = 32;
   localparam int COUNT_BITS = 5;

   typedef struct packed {
      op_type                 op;
      logic [PRIO_BITS-1:0]   priority_req;
      logic [WORD_BITS-1:0]   payload;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [COUNT_BITS-1:0]  entry_count;
      logic                   head_valid;
      logic [WORD_BITS-1:0]   head_payload;
      logic [PRIO_BITS-1:0]   head_priority;
   } rsp_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic                   insert;
      logic                   remove;
      logic                   clear;
      logic [PRIO_BITS-1:0]   prio;
   } cmd_type;

endpackage

// ----- rtl/spq_cell.sv -----
// One slot of the queue chain: holds an entry, shifts left or right on command.
`timescale 1ns / 1ps

module spq_cell #(
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  spq_pkg::cmd_type                  cmd,
   input  logic [PAYLOAD_BITS-1:0]           new_payload,
   input  logic                              left_keep,
   input  logic                              left_occ,
   input  logic [spq_pkg::PRIO_BITS-1:0]     left_prio,
   input  logic [PAYLOAD_BITS-1:0]           left_payload,
   input  logic                              right_occ,
   input  logic [spq_pkg::PRIO_BITS-1:0]     right_prio,
   input  logic [PAYLOAD_BITS-1:0]           right_payload,
   output logic                              occ,
   output logic [spq_pkg::PRIO_BITS-1:0]     prio,
   output logic [PAYLOAD_BITS-1:0]           payload,
   output logic                              keep
);

   logic                              occ_ff, occ_in;
   logic [spq_pkg::PRIO_BITS-1:0]     prio_ff, prio_in;
   logic [PAYLOAD_BITS-1:0]           payload_ff, payload_in;

   // an entry of equal or higher priority stays where it is on insert
   assign keep = occ_ff && (prio_ff >= cmd.prio);

   always_comb begin
      occ_in     = occ_ff;
      prio_in    = prio_ff;
      payload_in = payload_ff;
      if (cmd.clear) begin
         occ_in = 1'b0;
      end else if (cmd.insert && !keep) begin
         if (left_keep) begin
            occ_in     = 1'b1;
            prio_in    = cmd.prio;
            payload_in = new_payload;
         end else begin
            occ_in     = left_occ;
            prio_in    = left_prio;
            payload_in = left_payload;
         end
      end else if (cmd.remove) begin
         occ_in     = right_occ;
         prio_in    = right_prio;
         payload_in = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff    <= prio_in;
      payload_ff <= payload_in;
   end

   assign occ     = occ_ff;
   assign prio    = prio_ff;
   assign payload = payload_ff;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Sorted priority queue: top level with the cell chain, entry count and result register.
`timescale 1ns / 1ps

// Takes one operation per clock (insert, remove head, clear) and reports one result word in
// the following cycle on rsp_valid/rsp_word; the receiver cannot hold results off, so each
// word must be taken in the one cycle it is shown. busy is high only during reset. Every cell
// compares its own priority with the incoming one in parallel and shifts its entry by one
// slot, so an insert or remove moves the whole chain together whatever the occupancy.
// Entries of equal priority leave in arrival order; an insert into a full queue is dropped
// and a remove on an empty queue is ignored, each flagged in the status field.
module sorted_priority_queue #(
   parameter int CAPACITY     = 16,
   parameter int TOP_PRIORITY = 255,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  spq_pkg::req_type  req_word,
   output logic              rsp_valid,
   output spq_pkg::rsp_type  rsp_word
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [spq_pkg::PRIO_BITS-1:0] TOP_SAT =
      (TOP_PRIORITY > 255) ? 8'd255 : 8'(TOP_PRIORITY);

   logic                                  accept;
   logic                                  full, empty;
   logic                                  ins_go, rem_go, clr_go;
   logic [spq_pkg::PRIO_BITS-1:0]         prio_sat;
   logic [PAYLOAD_BITS+spq_pkg::WORD_BITS-1:0] in_ext, head_ext;
   logic [PAYLOAD_BITS-1:0]               new_payload;
   spq_pkg::cmd_type                      cmd;

   logic [CNT_W-1:0]                      held_count_ff, held_count_in;
   logic [CNT_W+spq_pkg::COUNT_BITS-1:0]  cnt_ext;
   logic                                  rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type                   status_ff, status_in;

   logic [CAPACITY-1:0]                   occ_vec;
   logic [CAPACITY-1:0]                   keep_vec;
   logic [spq_pkg::PRIO_BITS-1:0]         prio_arr    [CAPACITY];
   logic [PAYLOAD_BITS-1:0]               payload_arr [CAPACITY];

   assign busy   = reset;
   assign accept = start && !busy;
   assign full   = (held_count_ff == CNT_W'(CAPACITY));
   assign empty  = (held_count_ff == '0);

   assign ins_go = accept && (req_word.op == spq_pkg::OP_INSERT) && !full;
   assign rem_go = accept && (req_word.op == spq_pkg::OP_REMOVE) && !empty;
   assign clr_go = accept && (req_word.op == spq_pkg::OP_CLEAR);

   assign prio_sat    = (req_word.priority_req > TOP_SAT) ? TOP_SAT : req_word.priority_req;
   assign in_ext      = {{PAYLOAD_BITS{1'b0}}, req_word.payload};
   assign new_payload = in_ext[PAYLOAD_BITS-1:0];

   assign cmd.insert = ins_go;
   assign cmd.remove = rem_go;
   assign cmd.clear  = clr_go;
   assign cmd.prio   = prio_sat;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                           left_keep, left_occ, right_occ;
      logic [spq_pkg::PRIO_BITS-1:0]  left_prio, right_prio;
      logic [PAYLOAD_BITS-1:0]        left_payload, right_payload;

      if (i == 0) begin : g_head
         assign left_keep    = 1'b1;
         assign left_occ     = 1'b0;
         assign left_prio    = '0;
         assign left_payload = '0;
      end else begin : g_mid
         assign left_keep    = keep_vec[i-1];
         assign left_occ     = occ_vec[i-1];
         assign left_prio    = prio_arr[i-1];
         assign left_payload = payload_arr[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_occ     = 1'b0;
         assign right_prio    = '0;
         assign right_payload = '0;
      end else begin : g_body
         assign right_occ     = occ_vec[i+1];
         assign right_prio    = prio_arr[i+1];
         assign right_payload = payload_arr[i+1];
      end

      spq_cell #(
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .new_payload   (new_payload),
         .left_keep     (left_keep),
         .left_occ      (left_occ),
         .left_prio     (left_prio),
         .left_payload  (left_payload),
         .right_occ     (right_occ),
         .right_prio    (right_prio),
         .right_payload (right_payload),
         .occ           (occ_vec[i]),
         .prio          (prio_arr[i]),
         .payload       (payload_arr[i]),
         .keep          (keep_vec[i])
      );
   end

   always_comb begin
      held_count_in = held_count_ff;
      if (clr_go) begin
         held_count_in = '0;
      end else if (ins_go) begin
         held_count_in = held_count_ff + CNT_W'(1);
      end else if (rem_go) begin
         held_count_in = held_count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      status_in = spq_pkg::ST_DONE;
      if (req_word.op == spq_pkg::OP_INSERT && full) begin
         status_in = spq_pkg::ST_FULL;
      end else if (req_word.op == spq_pkg::OP_REMOVE && empty) begin
         status_in = spq_pkg::ST_EMPTY;
      end
   end

   assign rsp_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_count_ff <= held_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // hold the status of the last accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   assign cnt_ext  = {{spq_pkg::COUNT_BITS{1'b0}}, held_count_ff};
   assign head_ext = {{spq_pkg::WORD_BITS{1'b0}}, payload_arr[0]};

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_word.status        = status_ff;
   assign rsp_word.entry_count   = cnt_ext[spq_pkg::COUNT_BITS-1:0];
   assign rsp_word.head_valid    = occ_vec[0];
   assign rsp_word.head_payload  = occ_vec[0] ? head_ext[spq_pkg::WORD_BITS-1:0] : '0;
   assign rsp_word.head_priority = occ_vec[0] ? prio_arr[0] : '0;

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid_ff)
      else $error("result without an accepted word");

   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_vec) == int'(held_count_ff))
      else $error("cell occupancy disagrees with entry count");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      occ_vec[0] == (held_count_ff != '0))
      else $error("head cell occupancy disagrees with entry count");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.op == spq_pkg::OP_INSERT && full)
         |=> (held_count_ff == CNT_W'(CAPACITY)) && (status_ff == spq_pkg::ST_FULL))
      else $error("insert into full queue changed the count");

endmodule
